/* src/rcrb_pkg.sv */
// ----------------------------------------------------------------------------
// RTC counter register block package
// Shared item types, command codes and register map constants.
// ----------------------------------------------------------------------------
package rcrb_pkg;

  localparam int TICKS_PER_SECOND_DEF = 100;
  localparam int DAY_BITS_DEF         = 16;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  localparam int NUM_BYTES = 6;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [6:0] ADDR_MATCH = 7'h06;
  localparam logic [6:0] ADDR_LOAD  = 7'h0C;
  localparam logic [6:0] ADDR_CTRL  = 7'h12;

  localparam int CTRL_LOAD_BIT = 0;
  localparam int CTRL_SNAP_BIT = 1;
  localparam int CTRL_KEEP_BIT = 2;

  // Decoded command kinds.
  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_TICK  = 2'd3;

  // Register regions.
  localparam logic [2:0] REGION_NONE  = 3'd0;
  localparam logic [2:0] REGION_SNAP  = 3'd1;
  localparam logic [2:0] REGION_MATCH = 3'd2;
  localparam logic [2:0] REGION_LOAD  = 3'd3;
  localparam logic [2:0] REGION_CTRL  = 3'd4;

  typedef struct packed {
    logic [1:0] op;
    logic [6:0] addr;
    logic [7:0] wdata;
  } item_in_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       alarm_hit;
  } item_out_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] region;
    logic [2:0] idx;
    logic [7:0] wdata;
  } cmd_t;

endpackage

/* src/rcrb_front.sv */
// ----------------------------------------------------------------------------
// RTC front decoder
// Classifies an incoming item into a command kind, register region and index.
// ----------------------------------------------------------------------------
module rcrb_front (
  input  rcrb_pkg::item_in_t item,
  output rcrb_pkg::cmd_t     cmd
);

  logic [2:0] region;
  logic [2:0] idx;

  always_comb begin
    if (item.addr < rcrb_pkg::ADDR_MATCH) begin
      region = rcrb_pkg::REGION_SNAP;
      idx    = item.addr[2:0];
    end else if (item.addr < rcrb_pkg::ADDR_LOAD) begin
      region = rcrb_pkg::REGION_MATCH;
      idx    = 3'(item.addr - rcrb_pkg::ADDR_MATCH);
    end else if (item.addr < rcrb_pkg::ADDR_CTRL) begin
      region = rcrb_pkg::REGION_LOAD;
      idx    = 3'(item.addr - rcrb_pkg::ADDR_LOAD);
    end else if (item.addr == rcrb_pkg::ADDR_CTRL) begin
      region = rcrb_pkg::REGION_CTRL;
      idx    = 3'd0;
    end else begin
      region = rcrb_pkg::REGION_NONE;
      idx    = 3'd0;
    end
  end

  always_comb begin
    cmd.region = region;
    cmd.idx    = idx;
    cmd.wdata  = item.wdata;
    unique case (item.op)
      rcrb_pkg::OP_READ:  cmd.kind = rcrb_pkg::CMD_READ;
      // Writes to the read-only snapshot bytes and to unmapped space do nothing.
      rcrb_pkg::OP_WRITE: cmd.kind = (region == rcrb_pkg::REGION_NONE ||
                                      region == rcrb_pkg::REGION_SNAP) ?
                                     rcrb_pkg::CMD_NONE : rcrb_pkg::CMD_WRITE;
      rcrb_pkg::OP_TICK:  cmd.kind = rcrb_pkg::CMD_TICK;
      default:            cmd.kind = rcrb_pkg::CMD_NONE;
    endcase
  end

endmodule

/* src/rcrb_queue.sv */
// ----------------------------------------------------------------------------
// RTC command queue
// Small FIFO of decoded commands between the front decoder and the back end.
// ----------------------------------------------------------------------------
module rcrb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rcrb_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output rcrb_pkg::cmd_t head
);

  localparam int PtrW = (rcrb_pkg::QUEUE_DEPTH > 1) ? $clog2(rcrb_pkg::QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(rcrb_pkg::QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(rcrb_pkg::QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(rcrb_pkg::QUEUE_DEPTH);

  rcrb_pkg::cmd_t  entries [rcrb_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == FullCnt);
  assign empty   = (count == '0);
  assign head    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

/* src/rcrb_back.sv */
// ----------------------------------------------------------------------------
// RTC back end
// Holds the counters and register file, carries out commands and registers
// one result item per command.
// ----------------------------------------------------------------------------
module rcrb_back #(
  parameter int TICKS_PER_SECOND = rcrb_pkg::TICKS_PER_SECOND_DEF,
  parameter int DAY_BITS         = rcrb_pkg::DAY_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  rcrb_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output rcrb_pkg::item_out_t rsp
);

  // The hundredths counter must hold both a loaded 7-bit value and every count below the limit.
  localparam int HundW = ($clog2(TICKS_PER_SECOND) > 7) ? $clog2(TICKS_PER_SECOND) : 7;
  localparam logic [HundW:0] HundLimit = (HundW + 1)'(TICKS_PER_SECOND);

  logic [HundW-1:0]    hundredths;
  logic [5:0]          seconds_count;
  logic [5:0]          minutes_count;
  logic [4:0]          hours_count;
  logic [DAY_BITS-1:0] day_count;
  logic [7:0]          snapshot_regs [rcrb_pkg::NUM_BYTES];
  logic [7:0]          load_regs     [rcrb_pkg::NUM_BYTES];
  logic [7:0]          match_regs    [rcrb_pkg::NUM_BYTES];
  logic [2:0]          control_bits;

  logic [HundW-1:0]    hundredths_next;
  logic [5:0]          seconds_next;
  logic [5:0]          minutes_next;
  logic [4:0]          hours_next;
  logic [DAY_BITS-1:0] day_next;

  logic [HundW:0]      hund_inc;
  logic [6:0]          sec_inc;
  logic [6:0]          min_inc;
  logic [5:0]          hour_inc;
  logic                hund_wrap;
  logic                sec_wrap;
  logic                min_wrap;
  logic                hour_wrap;

  logic [7:0]          cur_bytes  [rcrb_pkg::NUM_BYTES];
  logic [7:0]          next_bytes [rcrb_pkg::NUM_BYTES];
  logic                match_all;
  logic [7:0]          read_byte;
  logic                exec;

  assign exec    = cmd_valid && (!rsp_valid || rsp_ready);
  assign cmd_pop = exec;

  // Advance cascade: each stage wraps once its increment reaches the limit.
  assign hund_inc  = {1'b0, hundredths} + 1'b1;
  assign sec_inc   = {1'b0, seconds_count} + 1'b1;
  assign min_inc   = {1'b0, minutes_count} + 1'b1;
  assign hour_inc  = {1'b0, hours_count} + 1'b1;
  assign hund_wrap = (hund_inc >= HundLimit);
  assign sec_wrap  = (sec_inc >= 7'd60);
  assign min_wrap  = (min_inc >= 7'd60);
  assign hour_wrap = (hour_inc >= 6'd24);

  always_comb begin
    if (control_bits[rcrb_pkg::CTRL_LOAD_BIT]) begin
      hundredths_next = HundW'(load_regs[0][6:0]);
      seconds_next    = load_regs[1][5:0];
      minutes_next    = load_regs[2][5:0];
      hours_next      = load_regs[3][4:0];
      day_next        = DAY_BITS'({load_regs[5], load_regs[4]});
    end else begin
      hundredths_next = hund_wrap ? '0 : hund_inc[HundW-1:0];
      seconds_next    = seconds_count;
      minutes_next    = minutes_count;
      hours_next      = hours_count;
      day_next        = day_count;
      if (hund_wrap) begin
        seconds_next = sec_wrap ? '0 : sec_inc[5:0];
        if (sec_wrap) begin
          minutes_next = min_wrap ? '0 : min_inc[5:0];
          if (min_wrap) begin
            hours_next = hour_wrap ? '0 : hour_inc[4:0];
            if (hour_wrap) begin
              day_next = day_count + 1'b1;
            end
          end
        end
      end
    end
  end

  always_comb begin
    cur_bytes[0]  = 8'(hundredths);
    cur_bytes[1]  = {2'b00, seconds_count};
    cur_bytes[2]  = {2'b00, minutes_count};
    cur_bytes[3]  = {3'b000, hours_count};
    cur_bytes[4]  = day_count[7:0];
    cur_bytes[5]  = 8'(day_count >> 8);
    next_bytes[0] = 8'(hundredths_next);
    next_bytes[1] = {2'b00, seconds_next};
    next_bytes[2] = {2'b00, minutes_next};
    next_bytes[3] = {3'b000, hours_next};
    next_bytes[4] = day_next[7:0];
    next_bytes[5] = 8'(day_next >> 8);
  end

  always_comb begin
    match_all = 1'b1;
    for (int i = 0; i < rcrb_pkg::NUM_BYTES; i++) begin
      if (next_bytes[i] != match_regs[i]) begin
        match_all = 1'b0;
      end
    end
  end

  always_comb begin
    unique case (cmd.region)
      rcrb_pkg::REGION_SNAP:  read_byte = snapshot_regs[cmd.idx];
      rcrb_pkg::REGION_MATCH: read_byte = match_regs[cmd.idx];
      rcrb_pkg::REGION_LOAD:  read_byte = load_regs[cmd.idx];
      rcrb_pkg::REGION_CTRL:  read_byte = {5'b00000, control_bits};
      default:                read_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hundredths    <= '0;
      seconds_count <= '0;
      minutes_count <= '0;
      hours_count   <= '0;
      day_count     <= '0;
      control_bits  <= '0;
      for (int i = 0; i < rcrb_pkg::NUM_BYTES; i++) begin
        snapshot_regs[i] <= '0;
        load_regs[i]     <= '0;
        match_regs[i]    <= '0;
      end
    end else if (exec) begin
      unique case (cmd.kind)
        rcrb_pkg::CMD_TICK: begin
          hundredths    <= hundredths_next;
          seconds_count <= seconds_next;
          minutes_count <= minutes_next;
          hours_count   <= hours_next;
          day_count     <= day_next;
          control_bits[rcrb_pkg::CTRL_LOAD_BIT] <= 1'b0;
        end
        rcrb_pkg::CMD_WRITE: begin
          unique case (cmd.region)
            rcrb_pkg::REGION_MATCH: match_regs[cmd.idx] <= cmd.wdata;
            rcrb_pkg::REGION_LOAD:  load_regs[cmd.idx]  <= cmd.wdata;
            rcrb_pkg::REGION_CTRL: begin
              // A snapshot request is taken at once and never stored.
              if (cmd.wdata[rcrb_pkg::CTRL_SNAP_BIT]) begin
                for (int i = 0; i < rcrb_pkg::NUM_BYTES; i++) begin
                  snapshot_regs[i] <= cur_bytes[i];
                end
              end
              control_bits <= {cmd.wdata[rcrb_pkg::CTRL_KEEP_BIT], 1'b0,
                               cmd.wdata[rcrb_pkg::CTRL_LOAD_BIT]};
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (exec) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      rsp.rdata     <= (cmd.kind == rcrb_pkg::CMD_READ) ? read_byte : 8'h00;
      rsp.alarm_hit <= (cmd.kind == rcrb_pkg::CMD_TICK) && match_all;
    end
  end

endmodule

/* src/rtc_counter_register_block_unit.sv */
// ----------------------------------------------------------------------------
// RTC counter register block
// Each accepted item is queued; the back end executes it and registers the result.
// Throughput: one item per cycle while rsp_ready takes results; a two-entry command queue decouples the
// decoder from the counter back end, which executes one command per cycle unless stalled.
// Reset: counters, load, match and snapshot bytes and control bits clear to 0.
// ----------------------------------------------------------------------------
module rtc_counter_register_block_unit #(
  parameter int TICKS_PER_SECOND = rcrb_pkg::TICKS_PER_SECOND_DEF,
  parameter int DAY_BITS         = rcrb_pkg::DAY_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  rcrb_pkg::item_in_t  req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output rcrb_pkg::item_out_t rsp
);

  rcrb_pkg::cmd_t dec_cmd;
  rcrb_pkg::cmd_t head_cmd;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;

  assign req_ready = !q_full;

  rcrb_front u_front (
    .item (req),
    .cmd  (dec_cmd)
  );

  rcrb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (req_valid),
    .push_cmd (dec_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (head_cmd)
  );

  rcrb_back #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND),
    .DAY_BITS         (DAY_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!q_empty),
    .cmd       (head_cmd),
    .cmd_pop   (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
